/* rtl/urs_pkg.sv */
package urs_pkg;

    // Result field width, fixed whatever the word width
    localparam int SAMPLE_BITS = 32;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_LOWER_BOUND = 2'd0;
    localparam cfg_index_t CFG_UPPER_BOUND = 2'd1;

    // Reset pattern of upper_bound before it is cut to the word width
    localparam logic [31:0] UPPER_RESET = 32'hFFFF_FFFF;

endpackage

/* rtl/urs_cell.sv */
// One restoring division step: bring down one word bit, subtract the span if it fits.
module urs_cell #(
    parameter int WORD_BITS = 32,
    parameter int BIT_POS   = 31
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [WORD_BITS-1:0] span,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] in_word,
    input  logic [WORD_BITS-1:0] in_rem,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] out_word,
    output logic [WORD_BITS-1:0] out_rem
);

    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 fits;
    logic                 valid_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] rem_next;

    assign trial    = {in_rem, in_word[BIT_POS]};
    assign diff     = trial - {1'b0, span};
    assign fits     = trial >= {1'b0, span};
    assign rem_next = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        word_reg <= in_word;
        rem_reg  <= rem_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_rem   = rem_reg;

endmodule

/* rtl/uniform_range_sampler_top.sv */
// A result strobe (done) follows an accepted item through the urs_cell chain, then done_reg.
// Throughput: one item per cycle; busy stays low, so start may be held high indefinitely.
// A rejected item gives no strobe; the receiver cannot stall and need not.
// Reset (rst_n low, asynchronous) empties the pipeline and sets lower_bound to zero
// and upper_bound to all ones within 32 bits; no clearing pass follows.
module uniform_range_sampler_top
    import urs_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // item input, command style
    input  logic                   start,
    output logic                   busy,
    input  logic [WORD_BITS-1:0]   raw_word,
    // result, one cycle strobe
    output logic                   done,
    output logic [SAMPLE_BITS-1:0] sample,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_index_t             cfg_index,
    input  logic [WORD_BITS-1:0]   cfg_data
);

    localparam logic [WORD_BITS-1:0] UPPER_RESET_W = WORD_BITS'(UPPER_RESET);
    localparam logic [WORD_BITS-1:0] SPAN_RESET    = UPPER_RESET_W + 1'b1;

    // Configuration: the bounds, plus the span kept alongside so that the
    // division chain sees a plain register rather than a subtractor.
    logic [WORD_BITS-1:0] lower_reg;
    logic [WORD_BITS-1:0] upper_reg;
    logic [WORD_BITS-1:0] span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= UPPER_RESET_W;
            span_reg  <= SPAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOWER_BOUND:
                begin
                    lower_reg <= cfg_data;
                    span_reg  <= upper_reg - cfg_data + 1'b1;
                end
                CFG_UPPER_BOUND:
                begin
                    upper_reg <= cfg_data;
                    span_reg  <= cfg_data - lower_reg + 1'b1;
                end
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Division chain: cell k brings down word bit WORD_BITS-1-k, so after the
    // last cell the remainder is raw_word mod span. Each item advances one
    // cell per cycle, so a new item enters every cycle.
    logic                 chain_valid [0:WORD_BITS];
    logic [WORD_BITS-1:0] chain_word  [0:WORD_BITS];
    logic [WORD_BITS-1:0] chain_rem   [0:WORD_BITS];

    assign chain_valid[0] = start && !busy;
    assign chain_word[0]  = raw_word;
    assign chain_rem[0]   = '0;

    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_cell
        urs_cell #(
            .WORD_BITS (WORD_BITS),
            .BIT_POS   (WORD_BITS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .span      (span_reg),
            .in_valid  (chain_valid[k]),
            .in_word   (chain_word[k]),
            .in_rem    (chain_rem[k]),
            .out_valid (chain_valid[k+1]),
            .out_word  (chain_word[k+1]),
            .out_rem   (chain_rem[k+1])
        );
    end

    // Output stage: pick the value and decide acceptance.
    logic [WORD_BITS-1:0] last_word;
    logic [WORD_BITS-1:0] last_rem;
    logic [WORD_BITS-1:0] span_less_one;
    logic [WORD_BITS-1:0] shifted_rem;
    logic [WORD_BITS:0]   block_end;
    logic                 full_range;
    logic                 pow2_span;
    logic                 reject;
    logic [WORD_BITS-1:0] value;
    logic                 done_reg;
    logic                 done_next;
    logic [SAMPLE_BITS-1:0] sample_reg;

    assign last_word     = chain_word[WORD_BITS];
    assign last_rem      = chain_rem[WORD_BITS];
    assign span_less_one = span_reg - 1'b1;
    assign full_range    = span_reg == '0;
    assign pow2_span     = (span_reg & span_less_one) == '0;
    assign shifted_rem   = lower_reg + last_rem;

    // The word lies in the last, incomplete block of the span exactly when
    // the start of its block plus one span runs past the top of the word.
    assign block_end = {1'b0, last_word - last_rem} + {1'b0, span_reg};
    assign reject    = block_end[WORD_BITS];

    assign value     = full_range ? last_word : shifted_rem;
    assign done_next = chain_valid[WORD_BITS] && (full_range || pow2_span || !reject);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Hold the sample for its one strobe cycle; no reset on payload
    always_ff @(posedge clk)
    begin
        sample_reg <= SAMPLE_BITS'(value);
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

/* rtl/urs_checker.sv */
module urs_checker #(
    parameter int WORD_BITS = 32
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);

    // A strobe only ever follows an accepted item by the pipeline depth
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, WORD_BITS + 1))
        else $error("result strobe without an item accepted at the pipeline depth");

    // No item accepted, no strobe at the pipeline depth
    a_no_item_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(WORD_BITS + 1) !done)
        else $error("result strobe invented for a cycle with no item");

    // The pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result strobe straight after reset");

    // Items and configuration are never held off
    a_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("item or configuration channel stalled");

endmodule

bind uniform_range_sampler_top urs_checker #(
    .WORD_BITS (WORD_BITS)
) u_urs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);
